// ----- rtl/fpr_pkg.sv -----
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the framed packet receiver: status codes,
// control states, the result record and the frame layout constants.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// Default capacity of the packet store in bytes.
	localparam int FPR_BUFFER_BYTES = 32;

	// Frame layout: preamble, command and length make up the header.
	localparam logic [7:0] FPR_PREAMBLE     = 8'hA5;
	localparam int         FPR_HEADER_BYTES = 3;
	localparam int         FPR_MIN_BYTES    = 4;

	// Status reported with the closing result of a packet.
	typedef enum logic [2:0] {
		FPR_ST_OK           = 3'd0,
		FPR_ST_NO_FIRST     = 3'd1,
		FPR_ST_BAD_PREAMBLE = 3'd2,
		FPR_ST_TOO_SHORT    = 3'd3,
		FPR_ST_INCOMPLETE   = 3'd4,
		FPR_ST_BAD_CHECKSUM = 3'd5
	} fpr_status_t;

	// Receiver control states.
	typedef enum logic [1:0] {
		FPR_IDLE,
		FPR_COLLECT,
		FPR_DRAIN
	} fpr_state_t;

	// One result record.
	typedef struct packed {
		fpr_status_t status;
		logic [7:0]  command;
		logic [7:0]  length;
		logic [7:0]  data_byte;
		logic        data_valid;
		logic        last;
	} fpr_result_t;

endpackage

// ----- rtl/fpr_in_if.sv -----
// ----------------------------------------------------------------------------
// fpr_in_if
// Event channel into the receiver: a received byte or a gap timeout.
// ----------------------------------------------------------------------------
interface fpr_in_if;

	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink   (input valid, input mode, input byte_value, output ready);

endinterface

// ----- rtl/fpr_out_if.sv -----
// ----------------------------------------------------------------------------
// fpr_out_if
// Result channel out of the receiver: payload bytes and the closing status.
// ----------------------------------------------------------------------------
interface fpr_out_if;

	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] command;
	logic [7:0] length;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       last;

	modport source (output valid, output status, output command, output length,
		output data_byte, output data_valid, output last, input ready);
	modport sink   (input valid, input status, input command, input length,
		input data_byte, input data_valid, input last, output ready);

endinterface

// ----- rtl/fpr_store.sv -----
// ----------------------------------------------------------------------------
// fpr_store
// Packet byte store: one write port and one read port with registered read
// data. The read address is the next payload position, so the byte is
// ready when the next drain transaction arrives.
// ----------------------------------------------------------------------------
module fpr_store
	import fpr_pkg::*;
#(
	parameter int BUFFER_BYTES = FPR_BUFFER_BYTES,
	localparam int AW = $clog2(BUFFER_BYTES)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/fpr_core.sv -----
// ----------------------------------------------------------------------------
// fpr_core
// Receiver control: collects the frame, keeps the running checksum, checks
// the finished packet and steps through the payload bytes.
// ----------------------------------------------------------------------------
module fpr_core
	import fpr_pkg::*;
#(
	parameter int BUFFER_BYTES = FPR_BUFFER_BYTES,
	localparam int AW = $clog2(BUFFER_BYTES),
	localparam int CW = $clog2(BUFFER_BYTES + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	fpr_in_if.sink        rx,
	input  logic          out_free,
	output fpr_result_t   result,
	output logic          result_vld,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data
);

	fpr_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    cmd_q, cmd_d;
	logic [7:0]    len_q, len_d;
	logic [7:0]    d3_q, d3_d;
	logic [7:0]    ck_q, ck_d;
	logic [AW-1:0] pos_q, pos_d;
	logic          accept;
	logic          fin;
	logic [7:0]    cmd_f;
	logic [7:0]    len_f;
	logic [7:0]    want;
	fpr_status_t   st_f;

	assign rx.ready = out_free;
	assign accept   = rx.valid && out_free;
	assign wr_data  = rx.byte_value;

	// State and packet registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FPR_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sum_q   <= sum_d;
			pos_q   <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		len_q <= len_d;
		d3_q  <= d3_d;
		ck_q  <= ck_d;
	end

	// Next state, store writes and the result of the accepted transaction.
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		sum_d      = sum_q;
		cmd_d      = cmd_q;
		len_d      = len_q;
		d3_d       = d3_q;
		ck_d       = ck_q;
		pos_d      = pos_q;
		fin        = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		result_vld = 1'b0;
		result     = '0;
		cmd_f      = '0;
		len_f      = '0;
		want       = '0;
		st_f       = FPR_ST_OK;

		unique case (state_q)
			FPR_IDLE: begin
				if (accept) begin
					if (rx.mode) begin
						result_vld    = 1'b1;
						result.status = FPR_ST_NO_FIRST;
						result.last   = 1'b1;
					end else if (rx.byte_value != FPR_PREAMBLE) begin
						result_vld    = 1'b1;
						result.status = FPR_ST_BAD_PREAMBLE;
						result.last   = 1'b1;
					end else begin
						wr_en   = 1'b1;
						cnt_d   = CW'(1);
						sum_d   = rx.byte_value;
						state_d = FPR_COLLECT;
					end
				end
			end
			FPR_COLLECT: begin
				if (accept) begin
					if (rx.mode) begin
						fin = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = cnt_q[AW-1:0];
						if (cnt_q == CW'(1)) begin
							cmd_d = rx.byte_value;
						end
						if (cnt_q == CW'(2)) begin
							len_d = rx.byte_value;
						end
						if (cnt_q == CW'(FPR_HEADER_BYTES)) begin
							d3_d = rx.byte_value;
						end
						// The checksum byte sits right after the declared payload.
						if (cnt_q >= CW'(FPR_HEADER_BYTES) &&
							9'(cnt_q) == 9'(FPR_HEADER_BYTES) + {1'b0, len_q}) begin
							ck_d = rx.byte_value;
						end
						// Header and payload bytes enter the running sum.
						if (cnt_q < CW'(FPR_HEADER_BYTES) ||
							(9'(cnt_q) - 9'(FPR_HEADER_BYTES)) < {1'b0, len_q}) begin
							sum_d = sum_q + rx.byte_value;
						end
						cnt_d = cnt_q + CW'(1);
						if (cnt_d == CW'(BUFFER_BYTES)) begin
							fin = 1'b1;
						end
					end
				end
			end
			FPR_DRAIN: begin
				if (accept) begin
					result_vld     = 1'b1;
					result.command = cmd_q;
					result.length  = len_q;
					if (8'(pos_q) < len_q) begin
						result.data_byte  = rd_data;
						result.data_valid = 1'b1;
						pos_d             = pos_q + AW'(1);
					end else begin
						result.last = 1'b1;
						pos_d       = '0;
						state_d     = FPR_IDLE;
					end
				end
			end
			default: begin
				state_d = FPR_IDLE;
			end
		endcase

		// Packet check at the end of collection.
		if (fin) begin
			cmd_f = (cnt_d >= CW'(2)) ? cmd_d : 8'h00;
			len_f = (cnt_d >= CW'(3)) ? len_d : 8'h00;
			want  = 8'h00 - sum_d;
			if (cnt_d < CW'(FPR_MIN_BYTES)) begin
				st_f = FPR_ST_TOO_SHORT;
			end else if (9'(cnt_d) < 9'(FPR_MIN_BYTES) + {1'b0, len_f}) begin
				st_f = FPR_ST_INCOMPLETE;
			end else if (ck_d != want) begin
				st_f = FPR_ST_BAD_CHECKSUM;
			end else begin
				st_f = FPR_ST_OK;
			end
			result_vld     = 1'b1;
			result.command = cmd_f;
			result.length  = len_f;
			if (st_f == FPR_ST_OK && len_f != 8'h00) begin
				result.data_byte  = d3_d;
				result.data_valid = 1'b1;
				pos_d             = AW'(1);
				state_d           = FPR_DRAIN;
			end else begin
				result.status = st_f;
				result.last   = 1'b1;
				state_d       = FPR_IDLE;
			end
		end
	end

	// The store is read one payload position ahead of the drain.
	assign rd_addr = pos_d + AW'(FPR_HEADER_BYTES);

	// Every transaction taken while draining produces a result.
	a_drain_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q == FPR_DRAIN |-> result_vld)
		else $error("drain transaction without result");

	// A payload byte is never the closing result and always carries OK status.
	a_payload_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_vld && result.data_valid |-> !result.last && result.status == FPR_ST_OK)
		else $error("payload result marked last or with error status");

	// While collecting the byte count is at least one and stays below the store size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FPR_COLLECT |-> cnt_q != '0 && cnt_q < CW'(BUFFER_BYTES))
		else $error("byte count out of range while collecting");

endmodule

// ----- rtl/fpr_out_reg.sv -----
// ----------------------------------------------------------------------------
// fpr_out_reg
// Result register: holds one result until the sink takes it and tells the
// core when a new result may be loaded.
// ----------------------------------------------------------------------------
module fpr_out_reg
	import fpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  fpr_result_t d,
	output logic        free,
	fpr_out_if.source   res
);

	logic        vld_q;
	fpr_result_t data_q;

	// The register is free when empty or when its result leaves this cycle.
	assign free = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	assign res.valid      = vld_q;
	assign res.status     = data_q.status;
	assign res.command    = data_q.command;
	assign res.length     = data_q.length;
	assign res.data_byte  = data_q.data_byte;
	assign res.data_valid = data_q.data_valid;
	assign res.last       = data_q.last;

endmodule

// ----- rtl/framed_packet_receiver_top.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receiver_top
// Framed packet receiver with additive checksum.
// ----------------------------------------------------------------------------
// Each transaction on rx is one event: a received byte (mode 0) or a gap
// timeout (mode 1). A frame is the preamble 0xA5, a command byte, a length
// byte, the payload and a checksum byte equal to the negated 8-bit sum of all
// earlier bytes. Collection ends on a timeout or when BUFFER_BYTES bytes are
// stored; the packet is then checked. A good packet returns one payload byte
// per event that follows (the first with the event that ends collection) and
// then a closing result with last set; a failed packet returns one result
// with its error status. The core updates its state and loads the result
// register at the same clock edge, so rx accepts a new event every cycle as
// long as res is drained. The packet store has a registered read port that
// is addressed one payload byte ahead.
// ----------------------------------------------------------------------------
module framed_packet_receiver_top
	import fpr_pkg::*;
#(
	parameter int BUFFER_BYTES = FPR_BUFFER_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	fpr_in_if.sink    rx,
	fpr_out_if.source res
);

	localparam int AW = $clog2(BUFFER_BYTES);

	fpr_result_t   result;
	logic          result_vld;
	logic          out_free;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	// Frame control and checking.
	fpr_core #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.out_free  (out_free),
		.result    (result),
		.result_vld(result_vld),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// Packet byte store.
	fpr_store #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Result register toward the sink.
	fpr_out_reg u_out_reg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (result_vld),
		.d     (result),
		.free  (out_free),
		.res   (res)
	);

endmodule

// ----- sim/framed_packet_receiver_top_tb.sv -----
// ----------------------------------------------------------------------------
// framed_packet_receiver_top_tb
// Self-checking bench for the framed packet receiver. A short table of
// directed events covers the error statuses, an empty and a non-empty good
// frame and the byte extremes. Random frames follow: mostly well-formed, some
// with a broken checksum, cut short, padded with trailing bytes or oversized,
// mixed with stray bytes and idle timeouts. Each result is checked against
// its table row's expected value or an internal model of the receiver; the
// random frames run under three sender and receiver stall patterns.
// ----------------------------------------------------------------------------
module framed_packet_receiver_top_tb
	import fpr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD   = 12.0;
	localparam int  RESET_CYCLES = 5;
	localparam int  RANDOM_ITEMS = 1650;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  STALL_LIMIT  = 1000;
	localparam int  REPORT_LIMIT = 10;
	localparam int  DIR_ROWS     = 29;

	// One row of the directed table; want is used only when typed is set.
	typedef struct packed {
		logic        mode;
		logic [7:0]  value;
		logic        typed;
		fpr_result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpr_in_if  rx_ch ();
	fpr_out_if res_ch ();

	framed_packet_receiver_top #(
		.BUFFER_BYTES(FPR_BUFFER_BYTES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch.sink),
		.res   (res_ch.source)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// Directed events: idle timeout, bad preamble, short, incomplete, empty good
	// frame, bad checksum, then a two-byte payload that is drained.
	dir_row_t directed_rows [DIR_ROWS] = '{
		'{1'b1, 8'h00, 1'b1, '{FPR_ST_NO_FIRST,     8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hFF, 1'b1, '{FPR_ST_BAD_PREAMBLE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hA5, 1'b0, '0},
		'{1'b0, 8'h01, 1'b0, '0},
		'{1'b1, 8'h00, 1'b1, '{FPR_ST_TOO_SHORT,    8'h01, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hA5, 1'b0, '0},
		'{1'b0, 8'h10, 1'b0, '0},
		'{1'b0, 8'h03, 1'b0, '0},
		'{1'b0, 8'h11, 1'b0, '0},
		'{1'b1, 8'hFF, 1'b1, '{FPR_ST_INCOMPLETE,   8'h10, 8'h03, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hA5, 1'b0, '0},
		'{1'b0, 8'h00, 1'b0, '0},
		'{1'b0, 8'h00, 1'b0, '0},
		'{1'b0, 8'h5B, 1'b0, '0},
		'{1'b1, 8'h00, 1'b1, '{FPR_ST_OK,           8'h00, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hA5, 1'b0, '0},
		'{1'b0, 8'hFF, 1'b0, '0},
		'{1'b0, 8'h00, 1'b0, '0},
		'{1'b0, 8'h00, 1'b0, '0},
		'{1'b1, 8'h00, 1'b1, '{FPR_ST_BAD_CHECKSUM, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1}},
		'{1'b0, 8'hA5, 1'b0, '0},
		'{1'b0, 8'h07, 1'b0, '0},
		'{1'b0, 8'h02, 1'b0, '0},
		'{1'b0, 8'h11, 1'b0, '0},
		'{1'b0, 8'h22, 1'b0, '0},
		'{1'b0, 8'h1F, 1'b0, '0},
		'{1'b1, 8'h00, 1'b0, '0},
		'{1'b0, 8'h80, 1'b0, '0},
		'{1'b1, 8'h00, 1'b0, '0}
	};

	// Receiver model state.
	logic [7:0]  rx_store [FPR_BUFFER_BYTES];
	int          rx_count      = 0;
	bit          rx_collecting = 1'b0;
	bit          rx_draining   = 1'b0;
	logic [7:0]  rx_sum        = 8'h00;
	int          drain_idx     = 0;
	logic [7:0]  pkt_command   = 8'h00;
	logic [7:0]  pkt_length    = 8'h00;

	fpr_result_t pending_results [$];
	bit          pin_active = 1'b0;
	fpr_result_t pin_result = '0;

	int src_idle_pct  = 35;
	int snk_idle_pct  = 73;
	int stall_cycles  = 0;
	int mismatches    = 0;
	int events_in     = 0;
	int results_out   = 0;
	int random_items  = 0;
	int payload_bytes = 0;
	int status_hits [6] = '{default: 0};

	function automatic logic [7:0] stored_byte(input int idx);
		return (idx < FPR_BUFFER_BYTES) ? rx_store[idx] : 8'h00;
	endfunction

	function automatic string show_result(input fpr_result_t r);
		return $sformatf("st=%0d cmd=%02h len=%02h data=%02h dv=%0b last=%0b",
			r.status, r.command, r.length, r.data_byte, r.data_valid, r.last);
	endfunction

	// End of collection: check length, completeness and checksum.
	task automatic close_packet(output fpr_result_t r);
		fpr_status_t st;
		logic [7:0]  want_cs;
		rx_collecting = 1'b0;
		pkt_command = (rx_count >= 2) ? stored_byte(1) : 8'h00;
		pkt_length  = (rx_count >= 3) ? stored_byte(2) : 8'h00;
		if (rx_count < FPR_MIN_BYTES) begin
			st = FPR_ST_TOO_SHORT;
		end else if (rx_count < FPR_MIN_BYTES + int'(pkt_length)) begin
			st = FPR_ST_INCOMPLETE;
		end else begin
			want_cs = 8'h00 - rx_sum;
			st = (want_cs == stored_byte(FPR_HEADER_BYTES + int'(pkt_length))) ?
				FPR_ST_OK : FPR_ST_BAD_CHECKSUM;
		end
		if (st == FPR_ST_OK && pkt_length != 8'h00) begin
			rx_draining = 1'b1;
			drain_idx = 1;
			r = '{FPR_ST_OK, pkt_command, pkt_length, stored_byte(FPR_HEADER_BYTES),
				1'b1, 1'b0};
		end else begin
			r = '{st, pkt_command, pkt_length, 8'h00, 1'b0, 1'b1};
		end
	endtask

	// Advance the model by one event; has_res tells whether a result follows.
	task automatic step_receiver(input logic m, input logic [7:0] b,
		output bit has_res, output fpr_result_t r);
		has_res = 1'b1;
		r = '0;
		if (rx_draining) begin
			if (drain_idx < int'(pkt_length)) begin
				r = '{FPR_ST_OK, pkt_command, pkt_length,
					stored_byte(FPR_HEADER_BYTES + drain_idx), 1'b1, 1'b0};
				drain_idx++;
			end else begin
				r = '{FPR_ST_OK, pkt_command, pkt_length, 8'h00, 1'b0, 1'b1};
				rx_draining = 1'b0;
				drain_idx = 0;
			end
		end else if (!rx_collecting) begin
			if (m) begin
				r = '{FPR_ST_NO_FIRST, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
			end else if (b != FPR_PREAMBLE) begin
				r = '{FPR_ST_BAD_PREAMBLE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
			end else begin
				rx_store[0] = b;
				rx_count = 1;
				rx_sum = b;
				rx_collecting = 1'b1;
				has_res = 1'b0;
			end
		end else if (m) begin
			close_packet(r);
		end else begin
			// Only header and declared payload bytes enter the running sum.
			if (rx_count < FPR_BUFFER_BYTES) begin
				rx_store[rx_count] = b;
				if (rx_count < FPR_HEADER_BYTES ||
					(rx_count - FPR_HEADER_BYTES) < int'(rx_store[2])) begin
					rx_sum = rx_sum + b;
				end
				rx_count++;
			end
			if (rx_count >= FPR_BUFFER_BYTES)
				close_packet(r);
			else
				has_res = 1'b0;
		end
	endtask

	// Result checking first, then prediction for the accepted event.
	always @(posedge clk) begin
		fpr_result_t got;
		fpr_result_t want;
		fpr_result_t predicted;
		bit          has_res;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{fpr_status_t'(res_ch.status), res_ch.command, res_ch.length,
					res_ch.data_byte, res_ch.data_valid, res_ch.last};
				results_out++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected result %s", $realtime, show_result(got));
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: mismatch, expected %s, got %s", $realtime,
								show_result(want), show_result(got));
					end
					if (want.data_valid)
						payload_bytes++;
					else if (int'(want.status) < 6)
						status_hits[int'(want.status)]++;
				end
			end
			if (rx_ch.valid && rx_ch.ready) begin
				events_in++;
				step_receiver(rx_ch.mode, rx_ch.byte_value, has_res, predicted);
				if (pin_active)
					pending_results.push_back(pin_result);
				else if (has_res)
					pending_results.push_back(predicted);
			end
			if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Result side stalls at random.
	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	// Present one event, with a random gap before it, and wait for acceptance.
	task automatic send_event(input logic m, input logic [7:0] b, input bit pinned,
		input fpr_result_t want);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pin_active = pinned;
		pin_result = want;
		rx_ch.valid <= 1'b1;
		rx_ch.mode <= m;
		rx_ch.byte_value <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// One random frame or stray event, then filler events while payload drains.
	task automatic send_frame();
		logic [7:0] frame [$];
		logic [7:0] len;
		logic [7:0] sum;
		logic [7:0] b;
		int         kind;
		int         flaw;
		int         i;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			send_event(1'b1, 8'($urandom), 1'b0, '0);
			random_items++;
		end else if (kind < 16) begin
			b = 8'($urandom);
			if (b == FPR_PREAMBLE)
				b = ~b;
			send_event(1'b0, b, 1'b0, '0);
			random_items++;
		end else begin
			i = $urandom_range(0, 99);
			if (i < 10)
				len = 8'($urandom);
			else if (i < 25)
				len = 8'($urandom_range(20, FPR_BUFFER_BYTES - FPR_MIN_BYTES));
			else
				len = 8'($urandom_range(0, 12));
			frame = '{FPR_PREAMBLE, 8'($urandom), len};
			for (i = 0; i < int'(len) && i < 40; i++)
				frame.push_back(8'($urandom));
			sum = 8'h00;
			foreach (frame[j])
				sum = sum + frame[j];
			frame.push_back(8'h00 - sum);
			// Damage some frames: bad checksum, cut short or trailing bytes.
			flaw = $urandom_range(0, 99);
			if (flaw < 12) begin
				frame[frame.size() - 1] = frame[frame.size() - 1] ^ 8'($urandom_range(1, 255));
			end else if (flaw < 24) begin
				frame = frame[0:$urandom_range(0, frame.size() - 2)];
			end else if (flaw < 36) begin
				repeat ($urandom_range(1, 5))
					frame.push_back(8'($urandom));
			end
			foreach (frame[j]) begin
				send_event(1'b0, frame[j], 1'b0, '0);
				random_items++;
				if (!rx_collecting)
					break;
			end
			if (rx_collecting) begin
				send_event(1'b1, 8'($urandom), 1'b0, '0);
				random_items++;
			end
		end
		while (rx_draining) begin
			send_event(1'($urandom), 8'($urandom), 1'b0, '0);
			random_items++;
		end
	endtask

	// Watchdog on cycles in which no transaction completes.
	initial begin
		wait (arst_n);
		while (stall_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
			STALL_LIMIT, pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		rx_ch.valid = 1'b0;
		rx_ch.mode = 1'b0;
		rx_ch.byte_value = 8'h00;
		res_ch.ready = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table.
		for (int r = 0; r < DIR_ROWS; r++)
			send_event(directed_rows[r].mode, directed_rows[r].value,
				directed_rows[r].typed, directed_rows[r].want);

		// Random frames in three stall patterns; the sender holds off at each
		// change until every outstanding result has come back.
		for (int phase = 0; phase < 3; phase++) begin
			rx_ch.valid <= 1'b0;
			do
				@(negedge clk);
			while (pending_results.size() != 0);
			case (phase)
				0: begin
					src_idle_pct = 35;
					snk_idle_pct = 73;
				end
				1: begin
					src_idle_pct = 73;
					snk_idle_pct = 35;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			while (random_items < (phase + 1) * RANDOM_ITEMS / 3)
				send_frame();
		end

		rx_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d events and %0d results, %0d of them payload bytes.",
			events_in, results_out, payload_bytes);
		$display("Closing statuses: ok %0d, no first byte %0d, bad preamble %0d, %s %0d, %s %0d, %s %0d.",
			status_hits[0], status_hits[1], status_hits[2], "too short", status_hits[3],
			"incomplete", status_hits[4], "bad checksum", status_hits[5]);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- framed_packet_receiver_top.f -----
rtl/fpr_pkg.sv
rtl/fpr_in_if.sv
rtl/fpr_out_if.sv
rtl/fpr_store.sv
rtl/fpr_core.sv
rtl/fpr_out_reg.sv
rtl/framed_packet_receiver_top.sv
sim/framed_packet_receiver_top_tb.sv
